>>> sv/jpd_pkg.sv
`default_nettype none

package jpd_pkg;

  localparam int SAMPLE_W = 8;
  localparam int DEAD_W   = 7;
  localparam int SCALE_W  = 15;
  localparam int MAG_W    = 15;
  localparam int POS_W    = 16;
  localparam int DIR_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int ROM_DEPTH  = 256;

  localparam int FULL_SCALE = 100 * 256;

  localparam logic [SAMPLE_W-1:0] X_LOW_RST  = 8'd0;
  localparam logic [SAMPLE_W-1:0] X_HIGH_RST = 8'd255;
  localparam logic [SAMPLE_W-1:0] X_MID_RST  = 8'd128;
  localparam logic [SAMPLE_W-1:0] Y_LOW_RST  = 8'd0;
  localparam logic [SAMPLE_W-1:0] Y_HIGH_RST = 8'd255;
  localparam logic [SAMPLE_W-1:0] Y_MID_RST  = 8'd128;
  localparam logic [DEAD_W-1:0]   DEAD_RST   = 7'd10;

  localparam logic [SCALE_W-1:0] RIGHT_SCALE_RST = SCALE_W'(FULL_SCALE / (255 - 128));
  localparam logic [SCALE_W-1:0] LEFT_SCALE_RST  = SCALE_W'(FULL_SCALE / (128 - 0));
  localparam logic [SCALE_W-1:0] UP_SCALE_RST    = SCALE_W'(FULL_SCALE / (255 - 128));
  localparam logic [SCALE_W-1:0] DOWN_SCALE_RST  = SCALE_W'(FULL_SCALE / (128 - 0));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_LOW  = 3'd0,
    REG_X_HIGH = 3'd1,
    REG_X_MID  = 3'd2,
    REG_Y_LOW  = 3'd3,
    REG_Y_HIGH = 3'd4,
    REG_Y_MID  = 3'd5,
    REG_DEAD_X = 3'd6,
    REG_DEAD_Y = 3'd7
  } cfg_reg_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_NEUTRAL = 3'd0,
    DIR_LEFT    = 3'd1,
    DIR_RIGHT   = 3'd2,
    DIR_UP      = 3'd3,
    DIR_DOWN    = 3'd4
  } dir_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } axis_t;

endpackage

`default_nettype wire

>>> sv/joystick_position_and_direction.sv
// An accepted input beat goes through the input register and the result register to m_axis_tvalid.
// Throughput: one beat per cycle while m_axis_tready stays high; one multiply per axis, the mapping sits
// between the input register and the result register.
// Scales come from a 256-entry constant table; the scale registers reload in the cycle after a write.
// Reset (rst, synchronous, active high) empties both stages and loads the
// default calibration: low 0, high 255, mid 128, deadzones 10 percent.
`default_nettype none

module joystick_position_and_direction (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // x_sample[7:0], y_sample[15:8]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // x_pos[15:0], y_pos[31:16], direction[34:32]
  input  wire logic        cfg_we,
  input  wire logic [jpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [jpd_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [jpd_pkg::SAMPLE_W-1:0] x_low, x_high, x_mid, y_low, y_high, y_mid;
  logic [jpd_pkg::DEAD_W-1:0]   dead_x, dead_y;
  logic [jpd_pkg::SCALE_W-1:0]  right_scale, left_scale, up_scale, down_scale;
  logic [jpd_pkg::SCALE_W-1:0]  right_scale_next, left_scale_next;
  logic [jpd_pkg::SCALE_W-1:0]  up_scale_next, down_scale_next;

  logic                         s1_valid;
  logic [jpd_pkg::SAMPLE_W-1:0] s1_x, s1_y;
  logic                         s1_adv;

  logic                         out_valid;
  logic [jpd_pkg::POS_W-1:0]    out_x, out_y;
  jpd_pkg::dir_t                out_dir;

  jpd_pkg::axis_t               xr, yr;
  logic [jpd_pkg::POS_W-1:0]    x_pos_next, y_pos_next;
  jpd_pkg::dir_t                dir_next;
  logic [jpd_pkg::MAG_W-1:0]    dead_lim_x, dead_lim_y;

  // scale table: floor(full scale / span), zero for an empty span
  logic [jpd_pkg::SCALE_W-1:0] scale_rom [jpd_pkg::ROM_DEPTH];
  assign scale_rom[0] = '0;
  for (genvar g = 1; g < jpd_pkg::ROM_DEPTH; g++) begin : g_rom
    localparam logic [jpd_pkg::SCALE_W-1:0] Q = jpd_pkg::SCALE_W'(jpd_pkg::FULL_SCALE / g);
    assign scale_rom[g] = Q;
  end

  function automatic logic [jpd_pkg::SAMPLE_W:0] span_of(
    input logic [jpd_pkg::SAMPLE_W-1:0] hi,
    input logic [jpd_pkg::SAMPLE_W-1:0] lo
  );
    span_of = {1'b0, hi} - {1'b0, lo};
  endfunction

  logic [jpd_pkg::SAMPLE_W:0] span_r, span_l, span_u, span_d;

  always_comb begin
    span_r = span_of(x_high, x_mid);
    span_l = span_of(x_mid, x_low);
    span_u = span_of(y_high, y_mid);
    span_d = span_of(y_mid, y_low);
    right_scale_next = span_r[jpd_pkg::SAMPLE_W] ? '0 : scale_rom[span_r[jpd_pkg::SAMPLE_W-1:0]];
    left_scale_next  = span_l[jpd_pkg::SAMPLE_W] ? '0 : scale_rom[span_l[jpd_pkg::SAMPLE_W-1:0]];
    up_scale_next    = span_u[jpd_pkg::SAMPLE_W] ? '0 : scale_rom[span_u[jpd_pkg::SAMPLE_W-1:0]];
    down_scale_next  = span_d[jpd_pkg::SAMPLE_W] ? '0 : scale_rom[span_d[jpd_pkg::SAMPLE_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_low  <= jpd_pkg::X_LOW_RST;
      x_high <= jpd_pkg::X_HIGH_RST;
      x_mid  <= jpd_pkg::X_MID_RST;
      y_low  <= jpd_pkg::Y_LOW_RST;
      y_high <= jpd_pkg::Y_HIGH_RST;
      y_mid  <= jpd_pkg::Y_MID_RST;
      dead_x <= jpd_pkg::DEAD_RST;
      dead_y <= jpd_pkg::DEAD_RST;
    end else if (cfg_we) begin
      case (jpd_pkg::cfg_reg_t'(cfg_index))
        jpd_pkg::REG_X_LOW:  x_low  <= cfg_data;
        jpd_pkg::REG_X_HIGH: x_high <= cfg_data;
        jpd_pkg::REG_X_MID:  x_mid  <= cfg_data;
        jpd_pkg::REG_Y_LOW:  y_low  <= cfg_data;
        jpd_pkg::REG_Y_HIGH: y_high <= cfg_data;
        jpd_pkg::REG_Y_MID:  y_mid  <= cfg_data;
        jpd_pkg::REG_DEAD_X: dead_x <= cfg_data[jpd_pkg::DEAD_W-1:0];
        jpd_pkg::REG_DEAD_Y: dead_y <= cfg_data[jpd_pkg::DEAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      right_scale <= jpd_pkg::RIGHT_SCALE_RST;
      left_scale  <= jpd_pkg::LEFT_SCALE_RST;
      up_scale    <= jpd_pkg::UP_SCALE_RST;
      down_scale  <= jpd_pkg::DOWN_SCALE_RST;
    end else begin
      right_scale <= right_scale_next;
      left_scale  <= left_scale_next;
      up_scale    <= up_scale_next;
      down_scale  <= down_scale_next;
    end
  end

  // handshake
  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_x <= s_axis_tdata[7:0];
      s1_y <= s_axis_tdata[15:8];
    end
  end

  function automatic jpd_pkg::axis_t map_axis(
    input logic [jpd_pkg::SAMPLE_W-1:0] s,
    input logic [jpd_pkg::SAMPLE_W-1:0] lo,
    input logic [jpd_pkg::SAMPLE_W-1:0] hi,
    input logic [jpd_pkg::SAMPLE_W-1:0] mid,
    input logic [jpd_pkg::SCALE_W-1:0]  ps,
    input logic [jpd_pkg::SCALE_W-1:0]  ns
  );
    jpd_pkg::axis_t r;
    logic [jpd_pkg::SAMPLE_W-1:0] d;
    logic [jpd_pkg::SCALE_W-1:0]  sc;
    logic [jpd_pkg::SAMPLE_W+jpd_pkg::SCALE_W-1:0] prod;
    r.neg = (s < mid);
    d     = r.neg ? (mid - s) : (s - mid);
    sc    = r.neg ? ns : ps;
    prod  = {{jpd_pkg::SCALE_W{1'b0}}, d} * {{jpd_pkg::SAMPLE_W{1'b0}}, sc};
    if ((!r.neg && s >= hi) || (r.neg && s <= lo)) begin
      r.mag = jpd_pkg::MAG_W'(jpd_pkg::FULL_SCALE);
    end else begin
      r.mag = prod[jpd_pkg::MAG_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    xr = map_axis(s1_x, x_low, x_high, x_mid, right_scale, left_scale);
    yr = map_axis(s1_y, y_low, y_high, y_mid, up_scale, down_scale);
    x_pos_next = xr.neg ? (-{1'b0, xr.mag}) : {1'b0, xr.mag};
    y_pos_next = yr.neg ? (-{1'b0, yr.mag}) : {1'b0, yr.mag};
    dead_lim_x = {dead_x, 8'h00};
    dead_lim_y = {dead_y, 8'h00};
    if (xr.mag < dead_lim_x && yr.mag < dead_lim_y) begin
      dir_next = jpd_pkg::DIR_NEUTRAL;
    end else if (xr.mag > yr.mag) begin
      dir_next = (xr.neg || xr.mag == '0) ? jpd_pkg::DIR_LEFT : jpd_pkg::DIR_RIGHT;
    end else begin
      dir_next = (yr.neg || yr.mag == '0) ? jpd_pkg::DIR_DOWN : jpd_pkg::DIR_UP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_x   <= x_pos_next;
      out_y   <= y_pos_next;
      out_dir <= dir_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_dir, out_y, out_x};

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_x) && $stable(s1_y))
    else $error("input stage lost a held beat");

  a_s1_fill: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> s1_valid)
    else $error("accepted beat not captured");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(out_x) <= 16'sd25600 && $signed(out_x) >= -16'sd25600
               && $signed(out_y) <= 16'sd25600 && $signed(out_y) >= -16'sd25600)
    else $error("position out of range");

  a_dir_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_dir == jpd_pkg::DIR_RIGHT || out_dir == jpd_pkg::DIR_UP)
    |-> ((out_dir == jpd_pkg::DIR_RIGHT) ? $signed(out_x) > 0 : $signed(out_y) > 0))
    else $error("direction disagrees with position sign");

endmodule

`default_nettype wire

>>> test/joystick_position_and_direction_tb.sv
`default_nettype none

module joystick_position_and_direction_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_LEN    = 400;
  localparam int PHASE_ITEMS = 104;

  typedef struct packed {
    logic [jpd_pkg::POS_W-1:0] x_pos;
    logic [jpd_pkg::POS_W-1:0] y_pos;
    jpd_pkg::dir_t             direction;
  } joy_result_t;

  class joy_scoreboard;
    logic [jpd_pkg::SAMPLE_W-1:0] x_low, x_high, x_mid, y_low, y_high, y_mid;
    logic [jpd_pkg::DEAD_W-1:0]   dead_x, dead_y;
    logic [jpd_pkg::SCALE_W-1:0]  right_scale, left_scale, up_scale, down_scale;
    joy_result_t                  pending_q[$];
    int                           errors;
    int                           beats_in;
    int                           beats_out;
    int                           dir_seen[5];

    function new();
      x_low = jpd_pkg::X_LOW_RST; x_high = jpd_pkg::X_HIGH_RST; x_mid = jpd_pkg::X_MID_RST;
      y_low = jpd_pkg::Y_LOW_RST; y_high = jpd_pkg::Y_HIGH_RST; y_mid = jpd_pkg::Y_MID_RST;
      dead_x = jpd_pkg::DEAD_RST; dead_y = jpd_pkg::DEAD_RST;
      errors = 0; beats_in = 0; beats_out = 0;
      foreach (dir_seen[i]) dir_seen[i] = 0;
      rescale();
    endfunction

    function logic [jpd_pkg::SCALE_W-1:0] span_scale(int hi, int lo);
      if (hi <= lo) return '0;
      return jpd_pkg::SCALE_W'(jpd_pkg::FULL_SCALE / (hi - lo));
    endfunction

    function void rescale();
      right_scale = span_scale(x_high, x_mid);
      left_scale  = span_scale(x_mid, x_low);
      up_scale    = span_scale(y_high, y_mid);
      down_scale  = span_scale(y_mid, y_low);
    endfunction

    function void set_reg(jpd_pkg::cfg_reg_t idx, logic [jpd_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        jpd_pkg::REG_X_LOW:  x_low  = val;
        jpd_pkg::REG_X_HIGH: x_high = val;
        jpd_pkg::REG_X_MID:  x_mid  = val;
        jpd_pkg::REG_Y_LOW:  y_low  = val;
        jpd_pkg::REG_Y_HIGH: y_high = val;
        jpd_pkg::REG_Y_MID:  y_mid  = val;
        jpd_pkg::REG_DEAD_X: dead_x = val[jpd_pkg::DEAD_W-1:0];
        jpd_pkg::REG_DEAD_Y: dead_y = val[jpd_pkg::DEAD_W-1:0];
        default: ;
      endcase
      rescale();
    endfunction

    function int axis_pos(int s, int lo, int hi, int mid, int pos_sc, int neg_sc);
      if (s >= mid) begin
        if (s >= hi) return jpd_pkg::FULL_SCALE;
        return (s - mid) * pos_sc;
      end
      if (s <= lo) return -jpd_pkg::FULL_SCALE;
      return -((mid - s) * neg_sc);
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void note_beat(logic [15:0] d);
      int xp, yp, ax, ay;
      joy_result_t r;
      xp = axis_pos(d[7:0], x_low, x_high, x_mid, right_scale, left_scale);
      yp = axis_pos(d[15:8], y_low, y_high, y_mid, up_scale, down_scale);
      ax = (xp < 0) ? -xp : xp;
      ay = (yp < 0) ? -yp : yp;
      if (ax < int'(dead_x) * 256 && ay < int'(dead_y) * 256)
        r.direction = jpd_pkg::DIR_NEUTRAL;
      else if (ax > ay)
        r.direction = (xp > 0) ? jpd_pkg::DIR_RIGHT : jpd_pkg::DIR_LEFT;
      else
        r.direction = (yp > 0) ? jpd_pkg::DIR_UP : jpd_pkg::DIR_DOWN;
      r.x_pos = jpd_pkg::POS_W'(xp);
      r.y_pos = jpd_pkg::POS_W'(yp);
      pending_q.push_back(r);
      beats_in++;
    endfunction

    function void check_beat(logic [39:0] d);
      joy_result_t e;
      beats_out++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", d);
        return;
      end
      e = pending_q.pop_front();
      if (d[15:0] !== e.x_pos || d[31:16] !== e.y_pos ||
          d[34:32] !== e.direction || d[39:35] !== 5'd0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch beat %0d: exp x %0d y %0d dir %0d, got x %0d y %0d dir %0d pad %b",
                   beats_out, $signed(e.x_pos), $signed(e.y_pos), e.direction,
                   $signed(d[15:0]), $signed(d[31:16]), d[34:32], d[39:35]);
      end else begin
        dir_seen[e.direction]++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [15:0]                    s_axis_tdata = '0;   // x_sample[7:0], y_sample[15:8]
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [39:0]                    m_axis_tdata;   // x_pos[15:0], y_pos[31:16], direction[34:32]
  logic                           cfg_we = 1'b0;
  logic [jpd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [jpd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  joy_scoreboard sb = new();

  logic [7:0] cal[8] = '{8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd128, 8'd10, 8'd10};
  bit tx_idle_en  = 1'b1;
  bit rx_idle_en  = 1'b1;
  bit rx_hold_req = 1'b0;
  int settings    = 1;
  int stall_cycles = 0;

  joystick_position_and_direction u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_beat(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("joystick_position_and_direction_tb NOT OK");
      $finish;
    end
  end

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(rx_idle_en && $urandom_range(99) < 16);
      end
    end
  end

  task automatic send_beat(input logic [7:0] xs, input logic [7:0] ys);
    while (tx_idle_en && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ys, xs};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input jpd_pkg::cfg_reg_t idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    cal[idx] = val;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] v[8]);
    for (int i = 0; i < 8; i++) write_reg(jpd_pkg::cfg_reg_t'(i), v[i]);
    cfg_we <= 1'b0;
    settings++;
    repeat (3) @(negedge clk);
  endtask

  // bias samples towards the calibration points so saturation edges get hit
  function automatic logic [7:0] pick_sample(logic [7:0] lo, logic [7:0] mid, logic [7:0] hi);
    int sel;
    logic [7:0] base;
    sel = $urandom_range(9);
    if (sel < 4) return 8'($urandom_range(255));
    base = (sel < 6) ? lo : (sel < 8) ? mid : hi;
    return base + 8'($urandom_range(4)) - 8'd2;
  endfunction

  function automatic logic [7:0] pick_dead();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd100;
      2: return 8'd127;
      default: return 8'($urandom_range(100));
    endcase
  endfunction

  task automatic random_setting(input int p);
    logic [7:0] v[8];
    int lo, mid, hi;
    for (int a = 0; a < 2; a++) begin
      if (p >= 4 && $urandom_range(3) == 0) begin
        lo = $urandom_range(255); mid = $urandom_range(255); hi = $urandom_range(255);
      end else begin
        lo  = ($urandom_range(4) == 0) ? 0 : $urandom_range(120);
        mid = $urandom_range(lo + 1, 200);
        hi  = ($urandom_range(4) == 0) ? 255 : $urandom_range(mid + 1, 255);
      end
      v[3*a]     = 8'(lo);
      v[3*a + 1] = 8'(hi);
      v[3*a + 2] = 8'(mid);
    end
    v[jpd_pkg::REG_DEAD_X] = pick_dead();
    v[jpd_pkg::REG_DEAD_Y] = pick_dead();
    apply_setting(v);
  endtask

  initial begin
    logic [7:0] v[8];
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (3) @(negedge clk);

    // reset calibration: saturation, ties, deadzone edge
    send_beat(8'd0,   8'd0);
    send_beat(8'd255, 8'd255);
    send_beat(8'd128, 8'd128);
    send_beat(8'd255, 8'd128);
    send_beat(8'd0,   8'd128);
    send_beat(8'd128, 8'd255);
    send_beat(8'd128, 8'd0);
    send_beat(8'd0,   8'd255);
    send_beat(8'd140, 8'd130);
    send_beat(8'd141, 8'd128);
    send_beat(8'd127, 8'd129);
    send_beat(8'd254, 8'd1);
    drain();

    // no deadzone: centre on both axes falls to down
    v = '{8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd128, 8'd0, 8'd0};
    apply_setting(v);
    send_beat(8'd128, 8'd128);
    send_beat(8'd129, 8'd128);
    send_beat(8'd127, 8'd128);
    drain();

    // empty left span, inverted up span, deadzones above and at 100
    v = '{8'd128, 8'd130, 8'd128, 8'd50, 8'd90, 8'd100, 8'd127, 8'd100};
    apply_setting(v);
    send_beat(8'd127, 8'd100);
    send_beat(8'd129, 8'd99);
    send_beat(8'd130, 8'd50);
    send_beat(8'd128, 8'd51);
    send_beat(8'd0,   8'd255);
    send_beat(8'd255, 8'd0);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        v = '{default: 8'd0};
        apply_setting(v);
      end else if (p == 1) begin
        v = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd127, 8'd127};
        apply_setting(v);
      end else begin
        random_setting(p);
      end
      tx_idle_en = (p != 2 && p != 3);
      rx_idle_en = (p != 2);
      if (p == 3) rx_hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_beat(pick_sample(cal[jpd_pkg::REG_X_LOW], cal[jpd_pkg::REG_X_MID],
                              cal[jpd_pkg::REG_X_HIGH]),
                  pick_sample(cal[jpd_pkg::REG_Y_LOW], cal[jpd_pkg::REG_Y_MID],
                              cal[jpd_pkg::REG_Y_HIGH]));
      drain();
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
    end

    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d sample pairs over %0d calibration settings, %0d results checked",
             sb.beats_in, settings, sb.beats_out);
    $display("directions seen: neutral %0d left %0d right %0d up %0d down %0d",
             sb.dir_seen[jpd_pkg::DIR_NEUTRAL], sb.dir_seen[jpd_pkg::DIR_LEFT],
             sb.dir_seen[jpd_pkg::DIR_RIGHT], sb.dir_seen[jpd_pkg::DIR_UP],
             sb.dir_seen[jpd_pkg::DIR_DOWN]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("joystick_position_and_direction_tb OK");
    end else begin
      $display("%0d failures, %0d results outstanding", sb.errors, sb.pending());
      $display("joystick_position_and_direction_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
